// ----- hdl/csvp_pkg.sv -----
// csvp_pkg: shared types, codes and helpers for the csv row/field parser
// no dependencies; imported by every csvp module and by csv_row_field_parser
`default_nettype none

package csvp_pkg;

   // longest field holds FIELD_LIMIT-1 characters
   localparam int FIELD_LIMIT = 1024;
   localparam int CHARS_W     = $clog2(FIELD_LIMIT);
   localparam logic [CHARS_W-1:0] CHARS_MAX = CHARS_W'(FIELD_LIMIT - 1);

   // result queue
   localparam int Q_DEPTH = 4;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   typedef enum logic [2:0] {
      MODE_PLAIN     = 3'd0,
      MODE_QUOTED    = 3'd1,
      MODE_QPEND     = 3'd2,
      MODE_CR        = 3'd3,
      MODE_CR_QUOTED = 3'd4,
      MODE_DISCARD   = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      KIND_CHAR      = 3'd0,
      KIND_FIELD_END = 3'd1,
      KIND_ROW_END   = 3'd2,
      KIND_BLANK     = 3'd3,
      KIND_UNMATCHED = 3'd4,
      KIND_OVERFLOW  = 3'd5,
      KIND_EOF       = 3'd6
   } kind_type;

   typedef enum logic {
      ACT_BYTE = 1'b0,
      ACT_EOF  = 1'b1
   } action_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_char;
      logic [15:0] field_number;
      logic [31:0] line_num;
      logic        last;
   } rsp_item_type;

   // results of one request, r0 first
   typedef struct packed {
      logic [1:0]   n;
      rsp_item_type r0;
      rsp_item_type r1;
   } step_out_type;

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      logic [15:0] r;
      r = (v == 16'hFFFF) ? v : v + 16'd1;
      return r;
   endfunction

   function automatic logic is_blank_byte(input logic [7:0] b);
      logic r;
      r = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
      return r;
   endfunction

   function automatic rsp_item_type make_rsp(input kind_type k, input logic [7:0] ch,
                                             input logic [15:0] fnum,
                                             input logic [31:0] line);
      rsp_item_type r;
      r.kind         = k;
      r.out_char     = ch;
      r.field_number = fnum;
      r.line_num     = line;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/csvp_step.sv -----
// csvp_step: parser state registers and the per-request decode logic
// depends on csvp_pkg
`default_nettype none

module csvp_step import csvp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  logic         item_action,
   input  logic [7:0]   item_byte,
   output step_out_type step_out
);

   mode_type            mode_ff, mode_in;
   logic                nonblank_ff, nonblank_in;
   logic                begun_ff, begun_in;
   logic [CHARS_W-1:0]  chars_ff, chars_in;
   logic [15:0]         fields_ff, fields_in;
   logic [31:0]         line_ff, line_in;
   logic                open_ff, open_in;

   always_comb begin
      mode_type     eff_mode;
      mode_type     fin_mode;
      logic         nb_new;
      logic [31:0]  line_cur;
      logic [15:0]  row_cnt;
      logic         fin_v;
      rsp_item_type fin_r;
      logic         do_add;
      logic         do_fin;
      logic         res_v;
      rsp_item_type res;
      logic [1:0]   n;
      rsp_item_type r0;
      rsp_item_type r1;

      mode_in     = mode_ff;
      nonblank_in = nonblank_ff;
      begun_in    = begun_ff;
      chars_in    = chars_ff;
      fields_in   = fields_ff;
      line_in     = line_ff;
      open_in     = open_ff;
      do_add      = 1'b0;
      do_fin      = 1'b0;
      res_v       = 1'b0;
      n           = 2'd0;

      // end of input never opens a new line
      line_cur = (open_ff || (item_action == ACT_EOF)) ? line_ff : line_ff + 32'd1;
      res      = make_rsp(KIND_CHAR, 8'd0, 16'd0, line_cur);
      r0       = res;
      r1       = res;

      // a pending quote followed by anything but a quote closes the quotes
      eff_mode = ((mode_ff == MODE_QPEND) && (item_byte != CH_QUOTE)) ? MODE_PLAIN : mode_ff;
      fin_mode = (item_action == ACT_EOF) ? mode_ff : eff_mode;
      nb_new   = nonblank_ff | ((item_action == ACT_BYTE) & ~is_blank_byte(item_byte));

      // line end result
      row_cnt = (begun_ff || fields_ff != 16'd0) ? sat_inc16(fields_ff) : fields_ff;
      fin_v   = (fin_mode != MODE_DISCARD);
      if (fin_mode == MODE_QUOTED || fin_mode == MODE_CR_QUOTED) begin
         fin_r = make_rsp(KIND_UNMATCHED, 8'd0, 16'd0, line_cur);
      end else if (!nb_new) begin
         fin_r = make_rsp(KIND_BLANK, 8'd0, 16'd0, line_cur);
      end else begin
         fin_r = make_rsp(KIND_ROW_END, 8'd0, row_cnt, line_cur);
      end

      if (item_action == ACT_BYTE) begin
         line_in     = line_cur;
         open_in     = 1'b1;
         nonblank_in = nb_new;
         mode_in     = eff_mode;
         case (eff_mode)
            MODE_PLAIN: begin
               if (item_byte == CH_LF) begin
                  do_fin = 1'b1;
               end else if (item_byte == CH_CR) begin
                  mode_in = MODE_CR;
               end else if (item_byte == CH_QUOTE) begin
                  mode_in  = MODE_QUOTED;
                  begun_in = 1'b1;
               end else if (item_byte == CH_COMMA) begin
                  fields_in = sat_inc16(fields_ff);
                  begun_in  = 1'b0;
                  chars_in  = '0;
                  res_v     = 1'b1;
                  res       = make_rsp(KIND_FIELD_END, 8'd0, sat_inc16(fields_ff), line_cur);
               end else begin
                  do_add = 1'b1;
               end
            end
            MODE_QUOTED: begin
               if (item_byte == CH_LF) begin
                  do_fin = 1'b1;
               end else if (item_byte == CH_CR) begin
                  mode_in = MODE_CR_QUOTED;
               end else if (item_byte == CH_QUOTE) begin
                  mode_in  = MODE_QPEND;
                  begun_in = 1'b1;
               end else begin
                  do_add = 1'b1;
               end
            end
            MODE_QPEND: begin
               // doubled quote: literal quote character
               mode_in = MODE_QUOTED;
               do_add  = 1'b1;
            end
            default: begin
               if (item_byte == CH_LF) begin
                  do_fin = 1'b1;
               end
            end
         endcase

         if (do_add) begin
            res_v = 1'b1;
            if (chars_ff >= CHARS_MAX) begin
               mode_in = MODE_DISCARD;
               res     = make_rsp(KIND_OVERFLOW, 8'd0, 16'd0, line_cur);
            end else begin
               chars_in = chars_ff + 1'b1;
               begun_in = 1'b1;
               res      = make_rsp(KIND_CHAR, item_byte, 16'd0, line_cur);
            end
         end

         if (do_fin) begin
            res_v = fin_v;
            res   = fin_r;
         end

         n  = {1'b0, res_v};
         r0 = res;
      end else begin
         do_fin = 1'b1;
         if (open_ff && fin_v) begin
            n  = 2'd2;
            r0 = fin_r;
         end else begin
            n  = 2'd1;
            r0 = make_rsp(KIND_EOF, 8'd0, 16'd0, line_cur);
         end
         r1 = make_rsp(KIND_EOF, 8'd0, 16'd0, line_cur);
      end

      if (do_fin) begin
         mode_in     = MODE_PLAIN;
         nonblank_in = 1'b0;
         begun_in    = 1'b0;
         chars_in    = '0;
         fields_in   = 16'd0;
         open_in     = 1'b0;
      end

      r0.last = (n == 2'd1);
      r1.last = 1'b1;

      step_out.n  = fire ? n : 2'd0;
      step_out.r0 = r0;
      step_out.r1 = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_PLAIN;
         nonblank_ff <= 1'b0;
         begun_ff    <= 1'b0;
         chars_ff    <= '0;
         fields_ff   <= 16'd0;
         line_ff     <= 32'd0;
         open_ff     <= 1'b0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         nonblank_ff <= nonblank_in;
         begun_ff    <= begun_in;
         chars_ff    <= chars_in;
         fields_ff   <= fields_in;
         line_ff     <= line_in;
         open_ff     <= open_in;
      end
   end

`ifndef SYNTHESIS
   a_closed_line_clean: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> (mode_ff == MODE_PLAIN) && (chars_ff == '0) && (fields_ff == 16'd0))
      else $error("closed line with leftover parse state");
   a_chars_in_range: assert property (@(posedge clock) disable iff (reset)
      chars_ff <= CHARS_MAX)
      else $error("field character count past limit");
   a_eof_closes: assert property (@(posedge clock) disable iff (reset)
      fire && (item_action == ACT_EOF) |=> !open_ff && (mode_ff == MODE_PLAIN))
      else $error("end of input left a line open");
`endif

endmodule

`default_nettype wire

// ----- hdl/csvp_rsp_queue.sv -----
// csvp_rsp_queue: small result queue, up to two writes and one read per cycle
// depends on csvp_pkg
`default_nettype none

module csvp_rsp_queue import csvp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  step_out_type push,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   rsp_item_type              entries_ff [Q_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         count_ff, count_in;
   logic                      pop;
   logic [QCNT_W-1:0]         count_after_pop;

   assign rsp_valid       = (count_ff != '0);
   assign rsp_item        = entries_ff[rd_ptr_ff];
   assign pop             = rsp_valid && !rsp_stall;
   assign count_after_pop = count_ff - QCNT_W'(pop);
   // a request may give two results
   assign room            = (count_after_pop <= QCNT_W'(Q_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push.n);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_after_pop + QCNT_W'(push.n);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.n == 2'd2) begin
         entries_ff[wr_ptr_ff + QPTR_W'(1)] <= push.r1;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(Q_DEPTH))
      else $error("result queue count past depth");
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (push.n != 2'd0) |-> ({1'b0, count_after_pop} + (QCNT_W + 1)'(push.n)
                            <= (QCNT_W + 1)'(Q_DEPTH)))
      else $error("result queue written without room");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");
`endif

endmodule

`default_nettype wire

// ----- hdl/csv_row_field_parser.sv -----
// csv_row_field_parser: top level of the byte-stream csv row and field parser
// depends on csvp_pkg, csvp_step and csvp_rsp_queue
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_action, req_in_byte
//   rsp_      out        rsp_valid/rsp_stall  rsp_kind, rsp_out_char, rsp_field_number,
//                                             rsp_line_num, rsp_last
//
// one request per cycle while req_stall is low: a byte is registered, decoded against
// the parse state and its result written to a four-entry result queue
// a request's first result goes through the request register, then the queue, to the port
// an end of input that closes an open line not being discarded gives two results, line end
// and end of input; the result port gives one result per cycle while rsp_stall is low
// reset is synchronous and clears parse state, line count and queue
// rsp_stall backs up into the queue; req_stall rises only when the queue cannot
// take the two results a request may give
`default_nettype none

module csv_row_field_parser import csvp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_out_char,
   output logic [15:0] rsp_field_number,
   output logic [31:0] rsp_line_num,
   output logic        rsp_last
);

   // request register stage
   logic         s1_valid_ff, s1_valid_in;
   logic         s1_action_ff;
   logic [7:0]   s1_byte_ff;
   logic         room;
   logic         fire;
   logic         load;
   step_out_type step_out;
   rsp_item_type head;

   // the registered request is decoded once the queue has space for its results
   assign fire      = s1_valid_ff && room;
   assign req_stall = s1_valid_ff && !room;
   assign load      = req_valid && !req_stall;
   assign s1_valid_in = load || (s1_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         s1_action_ff <= req_action;
         s1_byte_ff   <= req_in_byte;
      end
   end

   csvp_step u_step (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item_action (s1_action_ff),
      .item_byte   (s1_byte_ff),
      .step_out    (step_out)
   );

   csvp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_out),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_out_char     = head.out_char;
   assign rsp_field_number = head.field_number;
   assign rsp_line_num     = head.line_num;
   assign rsp_last         = head.last;

`ifndef SYNTHESIS
   a_held_request: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !fire |=> s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_action_ff))
      else $error("stalled request lost");
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire && (s1_action_ff == ACT_EOF) |=> rsp_valid)
      else $error("end of input gave no result");
   a_no_result_without_request: assert property (@(posedge clock) disable iff (reset)
      !fire |-> (step_out.n == 2'd0))
      else $error("results pushed without a request");
`endif

endmodule

`default_nettype wire
